[hw/rtl/av1sh_pkg.sv]
package av1sh_pkg;

    localparam int CfgMinSizeWidth = 17;
    localparam logic [16:0] MinSizeReset = 17'd16;
    localparam int PaddrWidth = 2;
    localparam logic [PaddrWidth-1:0] AddrMinSize = 2'd0;

    typedef enum logic [5:0] {
        P_PROFILE, P_STILL, P_REDUCED, P_RED_LEVEL, P_TIMING, P_UNITS, P_SCALE,
        P_EQUAL, P_UVLC_ZERO, P_UVLC_VAL, P_DM_PRESENT, P_BUF_LEN, P_DEC_TICK,
        P_REM_LEN, P_PRES_LEN, P_IDD_PRESENT, P_OP_CNT, P_OP_IDC, P_OP_LEVEL,
        P_OP_TIER, P_OP_DM, P_OP_DEC, P_OP_ENC, P_OP_LOWDELAY, P_OP_IDD_FLAG,
        P_OP_IDD, P_W_BITS, P_H_BITS, P_WIDTH, P_HEIGHT, P_FID, P_FID_LENS,
        P_SB3, P_TOOLS4, P_ORDER_HINT, P_JNT2, P_CHOOSE_SCT, P_FORCE_SCT,
        P_CHOOSE_IMV, P_FORCE_IMV, P_ORDER_BITS, P_SR3, P_HIGH_BD, P_TWELVE,
        P_MONO, P_CDP, P_DESC, P_RANGE, P_SUBX, P_SUBY, P_CSP, P_SEP_UV,
        P_FILM_GRAIN, P_DONE
    } t_step;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_BAD_PROFILE = 2'd1, ST_BAD_SIZE = 2'd2, ST_TRUNCATED = 2'd3
    } t_status;

    typedef enum logic [1:0] {S_IDLE, S_SHIFT, S_OUT} t_ctrl_state;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture byte
        logic shift;     // consume one bit
        logic restart;   // reset parser after a result
        logic emit;      // load output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last;      // captured byte is last
    } t_stat;

endpackage

[hw/rtl/av1sh_ctrl.sv]
module av1sh_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_out_busy,
    input  av1sh_pkg::t_stat  i_stat,
    output av1sh_pkg::t_cmd   o_cmd
);
    import av1sh_pkg::*;

    t_ctrl_state r_state, n_state;
    logic [2:0]  r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_cnt       = r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    n_state = i_stat.last ? S_OUT : S_IDLE;
                end
            end
            S_OUT: begin
                // wait for the output register to drain
                if (!i_out_busy) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.restart = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

[hw/rtl/av1sh_dp.sv]
module av1sh_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  av1sh_pkg::t_cmd                       i_cmd,
    output av1sh_pkg::t_stat                      o_stat,
    input  logic [7:0]                            i_payload_byte,
    input  logic                                  i_last_byte,
    input  logic [av1sh_pkg::CfgMinSizeWidth-1:0] i_min_size,
    input  logic                                  i_out_stall,
    output logic                                  o_out_busy,
    output logic                                  o_valid,
    output logic [1:0]                            o_status,
    output logic [1:0]                            o_profile,
    output logic [4:0]                            o_level_index,
    output logic                                  o_tier,
    output logic [16:0]                           o_frame_width,
    output logic [16:0]                           o_frame_height,
    output logic [3:0]                            o_bit_depth,
    output logic [2:0]                            o_chroma_layout,
    output logic [1:0]                            o_chroma_position,
    output logic                                  o_full_range,
    output logic [23:0]                           o_color_description,
    output logic                                  o_still_frame
);
    import av1sh_pkg::*;

    logic [7:0]  r_byte;
    logic        r_last;
    t_step       r_step, n_step;
    logic [5:0]  r_left, n_left;
    logic [31:0] r_acc, n_acc;
    logic [4:0]  r_ops, n_ops;
    logic [4:0]  r_bdb, n_bdb;
    logic [7:0]  r_szw, n_szw;
    logic [7:0]  r_flg, n_flg;
    logic [1:0]  r_err, n_err;
    logic [5:0]  r_uz, n_uz;
    logic [1:0]  r_prof, n_prof;
    logic [4:0]  r_lvl, n_lvl;
    logic        r_tier, n_tier;
    logic [16:0] r_fw, n_fw, r_fh, n_fh;
    logic [3:0]  r_bd, n_bd;
    logic [2:0]  r_cl, n_cl;
    logic [1:0]  r_cp, n_cp;
    logic        r_fr, n_fr;
    logic [23:0] r_cd, n_cd;
    logic        r_sp, n_sp;
    logic        r_ov;

    localparam int FRed = 0, FDm = 1, FIdd = 2, FOrd = 3, FHigh = 4, FTw = 5, FMono = 6,
                   FFirst = 7;

    assign o_stat.last = r_last;
    assign o_out_busy  = r_ov && i_out_stall;
    assign o_valid     = r_ov;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_payload_byte;
            r_last <= i_last_byte;
        end else if (i_cmd.shift) begin
            r_byte <= {r_byte[6:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_step <= P_PROFILE; r_left <= 6'd3; r_acc <= '0; r_ops <= '0;
            r_bdb <= '0; r_szw <= '0; r_flg <= '0; r_err <= ST_OK; r_uz <= '0;
            r_prof <= '0; r_lvl <= '0; r_tier <= 1'b0; r_fw <= '0; r_fh <= '0;
            r_bd <= 4'd8; r_cl <= '0; r_cp <= '0; r_fr <= 1'b0;
            r_cd <= 24'h020202; r_sp <= 1'b0;
        end else begin
            r_step <= n_step; r_left <= n_left; r_acc <= n_acc; r_ops <= n_ops;
            r_bdb <= n_bdb; r_szw <= n_szw; r_flg <= n_flg; r_err <= n_err; r_uz <= n_uz;
            r_prof <= n_prof; r_lvl <= n_lvl; r_tier <= n_tier; r_fw <= n_fw;
            r_fh <= n_fh; r_bd <= n_bd; r_cl <= n_cl; r_cp <= n_cp; r_fr <= n_fr;
            r_cd <= n_cd; r_sp <= n_sp;
        end
    end

    always_comb begin
        logic [31:0] v;
        logic        go_en;
        t_step       gs;
        logic [5:0]  gw;
        logic        first;
        logic [3:0]  bdv;
        logic [2:0]  clv;
        n_step = r_step; n_left = r_left; n_acc = r_acc; n_ops = r_ops;
        n_bdb = r_bdb; n_szw = r_szw; n_flg = r_flg; n_err = r_err; n_uz = r_uz;
        n_prof = r_prof; n_lvl = r_lvl; n_tier = r_tier; n_fw = r_fw; n_fh = r_fh;
        n_bd = r_bd; n_cl = r_cl; n_cp = r_cp; n_fr = r_fr; n_cd = r_cd; n_sp = r_sp;
        v = {r_acc[30:0], r_byte[7]};
        go_en = 1'b0; gs = P_DONE; gw = '0;
        first = r_flg[FFirst];
        bdv = r_bd; clv = r_cl;
        if (i_cmd.shift && r_err == ST_OK && r_step != P_DONE && r_left != 6'd0) begin
            n_acc  = v;
            n_left = r_left - 6'd1;
            if (r_left == 6'd1) begin
                go_en = 1'b1;
                case (r_step)
                    P_PROFILE: begin
                        if (v[2:0] > 3'd2) begin
                            n_prof = 2'd3; n_err = ST_BAD_PROFILE;
                        end else begin
                            n_prof = v[1:0]; gs = P_STILL; gw = 6'd1;
                        end
                    end
                    P_STILL: begin n_sp = v[0]; gs = P_REDUCED; gw = 6'd1; end
                    P_REDUCED: begin
                        if (v[0]) begin
                            n_flg[FRed] = 1'b1; gs = P_RED_LEVEL; gw = 6'd5;
                        end else begin
                            gs = P_TIMING; gw = 6'd1;
                        end
                    end
                    P_RED_LEVEL: begin
                        n_lvl = v[4:0]; n_tier = 1'b0; gs = P_W_BITS; gw = 6'd4;
                    end
                    P_TIMING: begin
                        if (v[0]) begin gs = P_UNITS; gw = 6'd32; end
                        else begin gs = P_IDD_PRESENT; gw = 6'd1; end
                    end
                    P_UNITS: begin gs = P_SCALE; gw = 6'd32; end
                    P_SCALE: begin gs = P_EQUAL; gw = 6'd1; end
                    P_EQUAL: begin
                        n_uz = '0;
                        if (v[0]) begin gs = P_UVLC_ZERO; gw = 6'd1; end
                        else begin gs = P_DM_PRESENT; gw = 6'd1; end
                    end
                    P_UVLC_ZERO: begin
                        if (!v[0]) begin
                            if (r_uz < 6'd32) n_uz = r_uz + 6'd1;
                            gs = P_UVLC_ZERO; gw = 6'd1;
                        end else if (r_uz == 6'd0 || r_uz >= 6'd32) begin
                            gs = P_DM_PRESENT; gw = 6'd1;
                        end else begin
                            gs = P_UVLC_VAL; gw = r_uz;
                        end
                    end
                    P_UVLC_VAL: begin gs = P_DM_PRESENT; gw = 6'd1; end
                    P_DM_PRESENT: begin
                        if (v[0]) begin
                            n_flg[FDm] = 1'b1; gs = P_BUF_LEN; gw = 6'd5;
                        end else begin
                            gs = P_IDD_PRESENT; gw = 6'd1;
                        end
                    end
                    P_BUF_LEN: begin n_bdb = v[4:0]; gs = P_DEC_TICK; gw = 6'd32; end
                    P_DEC_TICK: begin gs = P_REM_LEN; gw = 6'd5; end
                    P_REM_LEN: begin gs = P_PRES_LEN; gw = 6'd5; end
                    P_PRES_LEN: begin gs = P_IDD_PRESENT; gw = 6'd1; end
                    P_IDD_PRESENT: begin
                        if (v[0]) n_flg[FIdd] = 1'b1;
                        gs = P_OP_CNT; gw = 6'd5;
                    end
                    P_OP_CNT: begin
                        n_ops = v[4:0]; n_flg[FFirst] = 1'b1; gs = P_OP_IDC; gw = 6'd12;
                    end
                    P_OP_IDC: begin gs = P_OP_LEVEL; gw = 6'd5; end
                    P_OP_LEVEL, P_OP_TIER, P_OP_DM, P_OP_LOWDELAY, P_OP_IDD_FLAG,
                    P_OP_IDD: begin
                        // resolve the operating point chain: tier -> dm -> idd -> next op
                        logic to_tier, to_dm, to_idd;
                        to_tier = 1'b0; to_dm = 1'b0; to_idd = 1'b0;
                        case (r_step)
                            P_OP_LEVEL: begin
                                if (first) begin n_lvl = v[4:0]; n_tier = 1'b0; end
                                if (v[4:0] > 5'd7) begin gs = P_OP_TIER; gw = 6'd1; end
                                else to_tier = 1'b1;
                            end
                            P_OP_TIER: begin
                                if (first) n_tier = v[0];
                                to_tier = 1'b1;
                            end
                            P_OP_DM: begin
                                if (v[0]) begin
                                    gs = P_OP_DEC; gw = {1'b0, r_bdb} + 6'd1;
                                end else to_dm = 1'b1;
                            end
                            P_OP_LOWDELAY: to_dm = 1'b1;
                            P_OP_IDD_FLAG: begin
                                if (v[0]) begin gs = P_OP_IDD; gw = 6'd4; end
                                else to_idd = 1'b1;
                            end
                            default: to_idd = 1'b1;
                        endcase
                        if (to_tier) begin
                            if (r_flg[FDm]) begin gs = P_OP_DM; gw = 6'd1; end
                            else to_dm = 1'b1;
                        end
                        if (to_dm) begin
                            if (r_flg[FIdd]) begin gs = P_OP_IDD_FLAG; gw = 6'd1; end
                            else to_idd = 1'b1;
                        end
                        if (to_idd) begin
                            n_flg[FFirst] = 1'b0;
                            if (r_ops == 5'd0) begin gs = P_W_BITS; gw = 6'd4; end
                            else begin
                                n_ops = r_ops - 5'd1; gs = P_OP_IDC; gw = 6'd12;
                            end
                        end
                    end
                    P_OP_DEC: begin gs = P_OP_ENC; gw = {1'b0, r_bdb} + 6'd1; end
                    P_OP_ENC: begin gs = P_OP_LOWDELAY; gw = 6'd1; end
                    P_W_BITS: begin n_szw = {4'd0, v[3:0]}; gs = P_H_BITS; gw = 6'd4; end
                    P_H_BITS: begin
                        n_szw = {v[3:0], r_szw[3:0]};
                        gs = P_WIDTH; gw = {2'd0, r_szw[3:0]} + 6'd1;
                    end
                    P_WIDTH: begin
                        n_fw = v[16:0] + 17'd1;
                        gs = P_HEIGHT; gw = {2'd0, r_szw[7:4]} + 6'd1;
                    end
                    P_HEIGHT: begin
                        n_fh = v[16:0] + 17'd1;
                        if (r_fw < i_min_size || n_fh < i_min_size) n_err = ST_BAD_SIZE;
                        else if (r_flg[FRed]) begin gs = P_SB3; gw = 6'd3; end
                        else begin gs = P_FID; gw = 6'd1; end
                    end
                    P_FID: begin
                        if (v[0]) begin gs = P_FID_LENS; gw = 6'd7; end
                        else begin gs = P_SB3; gw = 6'd3; end
                    end
                    P_FID_LENS: begin gs = P_SB3; gw = 6'd3; end
                    P_SB3: begin
                        if (r_flg[FRed]) begin gs = P_SR3; gw = 6'd3; end
                        else begin gs = P_TOOLS4; gw = 6'd4; end
                    end
                    P_TOOLS4: begin gs = P_ORDER_HINT; gw = 6'd1; end
                    P_ORDER_HINT: begin
                        if (v[0]) begin n_flg[FOrd] = 1'b1; gs = P_JNT2; gw = 6'd2; end
                        else begin gs = P_CHOOSE_SCT; gw = 6'd1; end
                    end
                    P_JNT2: begin gs = P_CHOOSE_SCT; gw = 6'd1; end
                    P_CHOOSE_SCT, P_FORCE_SCT, P_CHOOSE_IMV, P_FORCE_IMV: begin
                        logic to_imv;
                        to_imv = 1'b0;
                        case (r_step)
                            P_CHOOSE_SCT: begin
                                gw = 6'd1;
                                gs = v[0] ? P_CHOOSE_IMV : P_FORCE_SCT;
                            end
                            P_FORCE_SCT: begin
                                if (v[0]) begin gs = P_CHOOSE_IMV; gw = 6'd1; end
                                else to_imv = 1'b1;
                            end
                            P_CHOOSE_IMV: begin
                                if (v[0]) to_imv = 1'b1;
                                else begin gs = P_FORCE_IMV; gw = 6'd1; end
                            end
                            default: to_imv = 1'b1;
                        endcase
                        if (to_imv) begin
                            gw = 6'd3;
                            gs = r_flg[FOrd] ? P_ORDER_BITS : P_SR3;
                        end
                    end
                    P_ORDER_BITS: begin gs = P_SR3; gw = 6'd3; end
                    P_SR3: begin gs = P_HIGH_BD; gw = 6'd1; end
                    P_HIGH_BD, P_TWELVE: begin
                        logic hi, tw;
                        hi = r_flg[FHigh]; tw = r_flg[FTw];
                        if (r_step == P_HIGH_BD) begin
                            hi = v[0];
                            if (v[0]) n_flg[FHigh] = 1'b1;
                        end else begin
                            tw = v[0];
                            if (v[0]) n_flg[FTw] = 1'b1;
                        end
                        if (r_step == P_HIGH_BD && r_prof == 2'd2 && v[0]) begin
                            gs = P_TWELVE; gw = 6'd1;
                        end else begin
                            if (r_prof == 2'd2 && hi) n_bd = tw ? 4'd12 : 4'd10;
                            else n_bd = hi ? 4'd10 : 4'd8;
                            gw = 6'd1;
                            gs = (r_prof == 2'd1) ? P_CDP : P_MONO;
                        end
                    end
                    P_MONO: begin
                        if (v[0]) n_flg[FMono] = 1'b1;
                        gs = P_CDP; gw = 6'd1;
                    end
                    P_CDP, P_DESC: begin
                        logic [23:0] cd;
                        cd = r_cd;
                        if (r_step == P_CDP && v[0]) begin
                            gs = P_DESC; gw = 6'd24;
                        end else begin
                            if (r_step == P_DESC) begin cd = v[23:0]; n_cd = v[23:0]; end
                            gw = 6'd1;
                            if (!r_flg[FMono] && cd == 24'h010D00) begin
                                n_fr = 1'b1; n_cl = 3'd0; gs = P_SEP_UV;
                            end else gs = P_RANGE;
                        end
                    end
                    P_RANGE, P_SUBX, P_SUBY: begin
                        logic to_sub;
                        to_sub = 1'b0;
                        if (r_step == P_RANGE) begin
                            n_fr = v[0];
                            if (r_flg[FMono]) begin
                                n_cl = 3'd7; n_cp = 2'd0; gs = P_FILM_GRAIN; gw = 6'd1;
                            end else if (r_prof == 2'd0) begin
                                clv = 3'd3; to_sub = 1'b1;
                            end else if (r_prof == 2'd1) begin
                                clv = 3'd0; to_sub = 1'b1;
                            end else if (bdv == 4'd12) begin
                                gs = P_SUBX; gw = 6'd1;
                            end else begin
                                clv = 3'd2; to_sub = 1'b1;
                            end
                        end else if (r_step == P_SUBX) begin
                            if (v[0]) begin gs = P_SUBY; gw = 6'd1; end
                            else begin clv = 3'd0; to_sub = 1'b1; end
                        end else begin
                            clv = {2'b01, v[0]}; to_sub = 1'b1;
                        end
                        if (to_sub) begin
                            n_cl = clv;
                            if (clv[1:0] == 2'b11) begin gs = P_CSP; gw = 6'd2; end
                            else begin gs = P_SEP_UV; gw = 6'd1; end
                        end
                    end
                    P_CSP: begin n_cp = v[1:0]; gs = P_SEP_UV; gw = 6'd1; end
                    P_SEP_UV: begin gs = P_FILM_GRAIN; gw = 6'd1; end
                    default: begin gs = P_DONE; gw = '0; end
                endcase
            end
        end
        if (go_en) begin
            n_step = gs; n_left = gw; n_acc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (i_cmd.emit) r_ov <= 1'b1;
        else if (!i_out_stall) r_ov <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_status <= (r_err != ST_OK) ? r_err : ((r_step == P_DONE) ? ST_OK : ST_TRUNCATED);
            o_profile <= r_prof; o_level_index <= r_lvl; o_tier <= r_tier;
            o_frame_width <= r_fw; o_frame_height <= r_fh; o_bit_depth <= r_bd;
            o_chroma_layout <= r_cl; o_chroma_position <= r_cp; o_full_range <= r_fr;
            o_color_description <= r_cd; o_still_frame <= r_sp;
        end
    end
endmodule

[hw/rtl/av1_sequence_header_parser_top.sv]
// AV1 sequence header parser.
// Input channel: one payload byte per transaction (i_payload_byte, i_last_byte),
// accepted when i_valid is high and o_stall is low. Bits are parsed MSB first,
// one bit per cycle, in the bit-serial parser's S_SHIFT state; the final bit of a
// non-last byte leads straight back to S_IDLE, where the next byte is taken.
// The byte marked last yields one result transaction on the output channel
// (o_valid, i_stall): after its final bit, S_OUT loads the output register once it
// is free and restarts the parser for the next header. Other bytes produce no result.
// A result waits in the output register while i_stall is high; the parser holds
// a last byte's state until the register drains, then continues.
// Configuration: APB register 0 (address 0) is min_frame_size, reset 16.
// Synchronous active-low reset clears the parser, the output valid and the
// register to their reset values.
module av1_sequence_header_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [1:0]  o_profile,
    output logic [4:0]  o_level_index,
    output logic        o_tier,
    output logic [16:0] o_frame_width,
    output logic [16:0] o_frame_height,
    output logic [3:0]  o_bit_depth,
    output logic [2:0]  o_chroma_layout,
    output logic [1:0]  o_chroma_position,
    output logic        o_full_range,
    output logic [23:0] o_color_description,
    output logic        o_still_frame
);
    import av1sh_pkg::*;

    logic [CfgMinSizeWidth-1:0] r_min_size;
    t_cmd  cmd;
    t_stat stat;
    logic  out_busy;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_min_size <= MinSizeReset;
        else if (psel && penable && pwrite && paddr == AddrMinSize)
            r_min_size <= pwdata[CfgMinSizeWidth-1:0];
    end
    assign prdata = (paddr == AddrMinSize) ? {15'd0, r_min_size} : 32'd0;

    av1sh_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_out_busy(out_busy),
        .i_stat(stat), .o_cmd(cmd)
    );

    av1sh_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_stat(stat),
        .i_payload_byte, .i_last_byte, .i_min_size(r_min_size),
        .i_out_stall(i_stall), .o_out_busy(out_busy), .o_valid,
        .o_status, .o_profile, .o_level_index, .o_tier, .o_frame_width,
        .o_frame_height, .o_bit_depth, .o_chroma_layout, .o_chroma_position,
        .o_full_range, .o_color_description, .o_still_frame
    );
endmodule

[hw/rtl/av1sh_checker.sv]
module av1sh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_last_byte,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic [3:0]  o_bit_depth
);
    // a byte occupies the parser: no back-to-back accepts
    a_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall) else $error("back to back accept");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status))) else $error("result dropped");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bit_depth == 4'd8 || o_bit_depth == 4'd10 || o_bit_depth == 4'd12))
        else $error("bad bit depth");

    a_nonlast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_last_byte && !o_valid) |-> ##8 !$rose(o_valid))
        else $error("result without last byte");
endmodule

bind av1_sequence_header_parser_top av1sh_checker u_av1sh_checker (
    .i_clk, .i_rst_n, .i_valid, .o_stall, .i_last_byte, .o_valid, .i_stall,
    .o_status, .o_bit_depth
);
